>>> sv/qlu_pkg.sv
// Shared constants and beat types of the Q-learning update unit.
`timescale 1ns / 1ps

package qlu_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_ACTIONS = 4;
    localparam int VALUE_WIDTH = 32;

    localparam int STATE_W  = $clog2(NUM_STATES);
    localparam int ACTION_W = $clog2(NUM_ACTIONS);
    localparam int ENTRIES  = NUM_STATES * NUM_ACTIONS;
    localparam int ENTRY_W  = $clog2(ENTRIES);

    localparam int REWARD_W  = 16;
    localparam int RESULT_W  = 32;
    localparam int FRAC_W    = 17;
    localparam int FRAC_BITS = 16;
    localparam int HALF_LSB  = 32768;

    localparam logic [FRAC_W-1:0] ONE_Q16          = 17'h10000;
    localparam logic [FRAC_W-1:0] LEARN_RATE_RESET = 17'd6554;
    localparam logic [FRAC_W-1:0] DISCOUNT_RESET   = 17'd58982;

    // datapath widths: value times factor, sample, difference, second product, new value
    localparam int PROD1_W   = VALUE_WIDTH + FRAC_W + 1;
    localparam int SCALED1_W = PROD1_W - FRAC_BITS;
    localparam int REWARD_Q_W = REWARD_W + FRAC_BITS;
    localparam int SAMPLE_W  = ((SCALED1_W > REWARD_Q_W) ? SCALED1_W : REWARD_Q_W) + 1;
    localparam int DIFF_W    = ((SAMPLE_W > VALUE_WIDTH) ? SAMPLE_W : VALUE_WIDTH) + 1;
    localparam int PROD2_W   = DIFF_W + FRAC_W + 1;
    localparam int SCALED2_W = PROD2_W - FRAC_BITS;
    localparam int NEWV_W    = ((SCALED2_W > VALUE_WIDTH) ? SCALED2_W : VALUE_WIDTH) + 1;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_LEARN_RATE = 1'b0;
    localparam logic REG_DISCOUNT   = 1'b1;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [STATE_W-1:0]         state_index;
        logic [ACTION_W-1:0]        action_index;
        logic [STATE_W-1:0]         next_state_index;
        logic signed [REWARD_W-1:0] reward;
    } item_t;

    typedef struct packed {
        logic [ACTION_W-1:0]        best_action;
        logic signed [RESULT_W-1:0] best_value;
        logic                       action_known;
        logic signed [RESULT_W-1:0] new_value;
    } result_t;

endpackage

>>> sv/tabular_q_learning_update_unit.sv
// Q table with update from transitions and greedy-action query.
`timescale 1ns / 1ps

//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        item_t
//  result    out        result_valid / result_stall    result_t
//  config    in / out   psel penable pwrite pready     paddr pwdata prdata
//
//  An update passes the row read, then two multiplies with the difference stage
//  between them, then the final stage; a query goes from the read to the final
//  stage. One item at a time, set by the one read-modify-write of the lane memories.
//  Reset clears the tried flags at once; the Q memory is not cleared, an untried
//  entry reads as zero. No clearing pass is needed.
//  A stalled result holds in the output register; the next item is taken meanwhile
//  and waits in its last stage until the register frees.
module tabular_q_learning_update_unit
    import qlu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [FRAC_W-1:0] learn_rate_reg;
    logic [FRAC_W-1:0] discount_reg;

    item_t item_reg;
    logic  item_fire;
    logic  can_load;
    logic  mem_wr;
    logic  cfg_wr;
    logic  reg_sel;

    logic [ENTRIES-1:0]     tried_reg;
    logic [NUM_ACTIONS-1:0] tried_a_sel;
    logic [NUM_ACTIONS-1:0] tried_b_sel;
    logic [NUM_ACTIONS-1:0] tried_a_reg;
    logic [NUM_ACTIONS-1:0] tried_b_reg;
    logic [ENTRY_W-1:0]     wr_entry;

    logic signed [VALUE_WIDTH-1:0] row_a [NUM_ACTIONS];
    logic signed [VALUE_WIDTH-1:0] row_b [NUM_ACTIONS];
    logic signed [VALUE_WIDTH-1:0] scan_row [NUM_ACTIONS];
    logic [NUM_ACTIONS-1:0]        scan_tried;

    logic                          scan_found;
    logic [ACTION_W-1:0]           scan_act;
    logic signed [VALUE_WIDTH-1:0] scan_val;
    logic signed [VALUE_WIDTH-1:0] old_sel;

    logic                          found_reg;
    logic [ACTION_W-1:0]           best_act_reg;
    logic signed [VALUE_WIDTH-1:0] best_val_reg;
    logic signed [VALUE_WIDTH-1:0] old_reg;
    logic signed [PROD1_W-1:0]     prod1_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [PROD2_W-1:0]     prod2_reg;

    logic [FRAC_W-1:0]             gamma_c;
    logic [FRAC_W-1:0]             alpha_c;
    logic signed [FRAC_W:0]        gamma_s;
    logic signed [FRAC_W:0]        alpha_s;
    logic signed [PROD1_W-1:0]     prod1_next;
    logic signed [PROD2_W-1:0]     prod2_next;
    logic signed [PROD1_W-1:0]     rnd1;
    logic signed [SCALED1_W-1:0]   scaled1;
    logic signed [REWARD_Q_W-1:0]  reward_q;
    logic signed [SAMPLE_W-1:0]    sample;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [PROD2_W-1:0]     rnd2;
    logic signed [SCALED2_W-1:0]   scaled2;
    logic signed [NEWV_W-1:0]      newv;
    logic signed [VALUE_WIDTH-1:0] nv_sat;

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    // handshakes
    assign item_stall   = (state_reg != ST_IDLE);
    assign item_fire    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign can_load     = !result_valid_reg || !result_stall;
    assign mem_wr       = (state_reg == ST_DONE) && can_load && (item_reg.mode == MODE_UPDATE);
    assign wr_entry     = {item_reg.state_index, item_reg.action_index};

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == REG_DISCOUNT) ? 32'(discount_reg) : 32'(learn_rate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RESET;
            discount_reg   <= DISCOUNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_LEARN_RATE: learn_rate_reg <= pwdata[FRAC_W-1:0];
                REG_DISCOUNT:   discount_reg   <= pwdata[FRAC_W-1:0];
                default:        learn_rate_reg <= learn_rate_reg;
            endcase
        end
    end

    // one memory per action lane, read at the current and the next state
    for (genvar g = 0; g < NUM_ACTIONS; g++) begin : g_lane
        logic signed [VALUE_WIDTH-1:0] lane_mem [NUM_STATES];
        logic signed [VALUE_WIDTH-1:0] lane_rd_a_reg;
        logic signed [VALUE_WIDTH-1:0] lane_rd_b_reg;

        always_ff @(posedge clk)
        begin
            if (item_fire)
            begin
                lane_rd_a_reg <= lane_mem[item.state_index];
                lane_rd_b_reg <= lane_mem[item.next_state_index];
            end
            if (mem_wr && (item_reg.action_index == ACTION_W'(g)))
            begin
                lane_mem[item_reg.state_index] <= nv_sat;
            end
        end

        assign row_a[g] = lane_rd_a_reg;
        assign row_b[g] = lane_rd_b_reg;
    end

    // tried flags, sampled alongside the memory read
    always_comb
    begin
        for (int a = 0; a < NUM_ACTIONS; a++)
        begin
            tried_a_sel[a] = tried_reg[{item.state_index, ACTION_W'(a)}];
            tried_b_sel[a] = tried_reg[{item.next_state_index, ACTION_W'(a)}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tried_reg <= '0;
        end
        else if (mem_wr)
        begin
            tried_reg[wr_entry] <= 1'b1;
        end
    end

    // greedy scan of the selected row; strict compare keeps the lowest index on ties
    always_comb
    begin
        for (int a = 0; a < NUM_ACTIONS; a++)
        begin
            scan_row[a] = (item_reg.mode == MODE_QUERY) ? row_a[a] : row_b[a];
        end
        scan_tried = (item_reg.mode == MODE_QUERY) ? tried_a_reg : tried_b_reg;
        scan_found = 1'b0;
        scan_act   = '0;
        scan_val   = '0;
        for (int a = 0; a < NUM_ACTIONS; a++)
        begin
            if (scan_tried[a] && (!scan_found || (scan_row[a] > scan_val)))
            begin
                scan_found = 1'b1;
                scan_act   = ACTION_W'(a);
                scan_val   = scan_row[a];
            end
        end
        old_sel = tried_a_reg[item_reg.action_index] ? row_a[item_reg.action_index] : '0;
    end

    // arithmetic
    assign gamma_c = (discount_reg > ONE_Q16) ? ONE_Q16 : discount_reg;
    assign alpha_c = (learn_rate_reg > ONE_Q16) ? ONE_Q16 : learn_rate_reg;
    assign gamma_s = $signed({1'b0, gamma_c});
    assign alpha_s = $signed({1'b0, alpha_c});

    assign prod1_next = best_val_reg * gamma_s;
    assign rnd1       = prod1_reg + PROD1_W'(HALF_LSB);
    assign scaled1    = $signed(rnd1[PROD1_W-1:FRAC_BITS]);
    assign reward_q   = $signed({item_reg.reward, {FRAC_BITS{1'b0}}});
    assign sample     = found_reg ? (SAMPLE_W'(reward_q) + SAMPLE_W'(scaled1))
                                  : SAMPLE_W'(reward_q);
    assign diff_next  = DIFF_W'(sample) - DIFF_W'(old_reg);
    assign prod2_next = diff_reg * alpha_s;
    assign rnd2       = prod2_reg + PROD2_W'(HALF_LSB);
    assign scaled2    = $signed(rnd2[PROD2_W-1:FRAC_BITS]);
    assign newv       = NEWV_W'(old_reg) + NEWV_W'(scaled2);

    always_comb
    begin
        if (newv > NEWV_W'(VALUE_MAX))
        begin
            nv_sat = VALUE_MAX;
        end
        else if (newv < NEWV_W'(VALUE_MIN))
        begin
            nv_sat = VALUE_MIN;
        end
        else
        begin
            nv_sat = newv[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        result_next = '0;
        if (item_reg.mode == MODE_QUERY)
        begin
            result_next.best_action  = best_act_reg;
            result_next.best_value   = RESULT_W'(best_val_reg);
            result_next.action_known = found_reg;
        end
        else
        begin
            result_next.new_value = RESULT_W'(nv_sat);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = (item_reg.mode == MODE_QUERY) ? ST_DONE : ST_MUL1;
            ST_MUL1: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && can_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            item_reg    <= item;
            tried_a_reg <= tried_a_sel;
            tried_b_reg <= tried_b_sel;
        end
        case (state_reg)
            ST_READ:
            begin
                found_reg    <= scan_found;
                best_act_reg <= scan_act;
                best_val_reg <= scan_val;
                old_reg      <= old_sel;
            end
            ST_MUL1: prod1_reg <= prod1_next;
            ST_DIFF: diff_reg  <= diff_next;
            ST_MUL2: prod2_reg <= prod2_next;
            ST_DONE:
            begin
                if (can_load)
                begin
                    result_reg <= result_next;
                end
            end
            default: prod1_reg <= prod1_reg;
        endcase
    end

    // checks
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the final stage");

    a_tried_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> tried_reg[wr_entry])
        else $error("written entry not marked tried");

    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.action_known) |->
            (result.best_value == '0) && (result.best_action == '0))
        else $error("empty row gave a non-zero best action or value");

    a_query_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.action_known) |-> (result.new_value == '0))
        else $error("query beat carries a new value");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> (state_reg == ST_READ) && item_stall)
        else $error("accepted beat did not start the read");

endmodule
